### hw/rtl/tsps_pkg.sv
package tsps_pkg;

    // Width of the two Q2.14 coefficient registers.
    localparam int COEF_BITS = 16;
    // The products are scaled up by 2^20 before rotation so the floor shifts
    // of the rotation steps keep enough fraction bits.
    localparam int PRESCALE_BITS = 20;
    // Number of rotation steps of the vectoring CORDIC.
    localparam int CORDIC_STEPS = 31;
    // Guard bits for vector growth (gain about 1.65, times sqrt 2).
    localparam int GUARD_BITS = 3;

    localparam logic signed [COEF_BITS-1:0] NUM_COEF_RESET = 16'sd24576;
    localparam logic signed [COEF_BITS-1:0] DEN_COEF_RESET = 16'sd14189;

    // Start angle of a vector that was folded into the right half plane.
    localparam logic [31:0] HALF_TURN = 32'h8000_0000;

    typedef enum logic [0:0] {
        REG_NUM_COEF = 1'b0,
        REG_DEN_COEF = 1'b1
    } t_reg_idx;

    // Fill state of the queue between the front and the back end.
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    // atan(2^-k) in units of 2^-32 turn.
    function automatic logic [31:0] atan_turn(input int unsigned k);
        logic [31:0] t;
        case (k)
            0:       t = 32'h2000_0000;
            1:       t = 32'h12E4_051E;
            2:       t = 32'h09FB_385B;
            3:       t = 32'h0511_11D4;
            4:       t = 32'h028B_0D43;
            5:       t = 32'h0145_D7E1;
            6:       t = 32'h00A2_F61E;
            7:       t = 32'h0051_7C55;
            8:       t = 32'h0028_BE53;
            9:       t = 32'h0014_5F2F;
            10:      t = 32'h000A_2F98;
            11:      t = 32'h0005_17CC;
            12:      t = 32'h0002_8BE6;
            13:      t = 32'h0001_45F3;
            14:      t = 32'h0000_A2FA;
            15:      t = 32'h0000_517D;
            16:      t = 32'h0000_28BE;
            17:      t = 32'h0000_145F;
            18:      t = 32'h0000_0A30;
            19:      t = 32'h0000_0518;
            20:      t = 32'h0000_028C;
            21:      t = 32'h0000_0146;
            22:      t = 32'h0000_00A3;
            23:      t = 32'h0000_0051;
            24:      t = 32'h0000_0029;
            25:      t = 32'h0000_0014;
            26:      t = 32'h0000_000A;
            27:      t = 32'h0000_0005;
            28:      t = 32'h0000_0003;
            29:      t = 32'h0000_0001;
            30:      t = 32'h0000_0001;
            default: t = 32'h0000_0000;
        endcase
        return t;
    endfunction

endpackage

### hw/rtl/three_step_phase_shift_top.sv
// Wrapped phase from three phase-shifted fringe samples. Each input word is
// one pixel: the three intensities of the same position in three fringe
// patterns, with the shadow-mask lit flag on tuser and the frame end on tlast.
// The block returns atan2((1-cos s)*(i3-i2), sin s*(2*i1-i2-i3)) as a signed
// binary angle in which 2^(PHASE_BITS-1) stands for pi; unlit pixels and a
// zero vector give angle zero, and phase_valid echoes the lit flag. The two
// coefficients are Q2.14 values written through the plain write port (index 0
// is one minus cosine of the shift, index 1 its sine) and reset to the values
// for a shift of 2*pi/3; write them only while no pixel is in flight. The
// block takes one pixel per clock while the queue has room and returns one per
// clock whenever the output side is ready. A pixel passes through the
// multiplier stage, the four-word queue, one pre-rotation stage, 31 CORDIC
// rotation stages of one step each and the rounding stage, which is the
// output register. The queue lets the input side keep accepting after the
// output side stalls, until the queue and the product register are full.
module three_step_phase_shift_top #(
    parameter int SAMPLE_BITS = 8,
    parameter int PHASE_BITS  = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Configuration write port.
    input  logic                               i_cfg_we,
    input  logic                               i_cfg_index,
    input  logic [tsps_pkg::COEF_BITS-1:0]     i_cfg_data,
    // Pixel input stream.
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // tdata fields, lowest bits first: sample_first, sample_second,
    // sample_third, then zero padding to whole bytes.
    input  logic [((3*SAMPLE_BITS+7)/8)*8-1:0] i_s_axis_tdata,
    // tuser fields: pixel_lit.
    input  logic [0:0]                         i_s_axis_tuser,
    input  logic                               i_s_axis_tlast,
    // Phase output stream.
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    // tdata fields, lowest bits first: wrapped_phase, then zero padding.
    output logic [((PHASE_BITS+7)/8)*8-1:0]    o_m_axis_tdata,
    // tuser fields: phase_valid.
    output logic [0:0]                         o_m_axis_tuser,
    output logic                               o_m_axis_tlast
);
    import tsps_pkg::*;

    localparam int IN_W   = ((3*SAMPLE_BITS+7)/8)*8;
    localparam int OUT_W  = ((PHASE_BITS+7)/8)*8;
    localparam int PB_NUM = COEF_BITS + SAMPLE_BITS + 1;
    localparam int PB_DEN = COEF_BITS + SAMPLE_BITS + 2;
    localparam int QW     = PB_NUM + PB_DEN + 2;

    t_q_stat               q_stat;
    logic                  q_push;
    logic [QW-1:0]         q_push_data;
    logic                  q_pop;
    logic [QW-1:0]         q_head;
    logic [PHASE_BITS-1:0] phase;

    // Front end: coefficient registers, sample differences and products.
    tsps_front #(
        .SAMPLE_BITS(SAMPLE_BITS),
        .IN_W       (IN_W),
        .QW         (QW)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .i_valid    (i_s_axis_tvalid),
        .o_ready    (o_s_axis_tready),
        .i_data     (i_s_axis_tdata),
        .i_lit      (i_s_axis_tuser[0]),
        .i_last     (i_s_axis_tlast),
        .i_q_stat   (q_stat),
        .o_push     (q_push),
        .o_push_data(q_push_data)
    );

    // Short queue so the input side waits on the output handshake only once it is full.
    tsps_queue #(
        .QW(QW)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (q_push),
        .i_push_data(q_push_data),
        .i_pop      (q_pop),
        .o_head     (q_head),
        .o_stat     (q_stat)
    );

    // Back end: vectoring CORDIC pipeline and rounding to the output width.
    tsps_cordic #(
        .SAMPLE_BITS(SAMPLE_BITS),
        .PHASE_BITS (PHASE_BITS),
        .QW         (QW)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (q_head),
        .i_q_stat(q_stat),
        .o_pop   (q_pop),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_phase (phase),
        .o_lit   (o_m_axis_tuser[0]),
        .o_last  (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = OUT_W'(phase);

endmodule

### hw/rtl/tsps_front.sv
module tsps_front #(
    parameter int SAMPLE_BITS = 8,
    parameter int IN_W        = 24,
    parameter int QW          = 53
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic                               i_cfg_index,
    input  logic [tsps_pkg::COEF_BITS-1:0]     i_cfg_data,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic [IN_W-1:0]                    i_data,
    input  logic                               i_lit,
    input  logic                               i_last,
    input  tsps_pkg::t_q_stat                  i_q_stat,
    output logic                               o_push,
    output logic [QW-1:0]                      o_push_data
);
    import tsps_pkg::*;

    localparam int PB_NUM = COEF_BITS + SAMPLE_BITS + 1;
    localparam int PB_DEN = COEF_BITS + SAMPLE_BITS + 2;

    logic signed [COEF_BITS-1:0] r_num_coef;
    logic signed [COEF_BITS-1:0] r_den_coef;

    logic                     r_valid;
    logic signed [PB_NUM-1:0] r_num;
    logic signed [PB_DEN-1:0] r_den;
    logic                     r_lit;
    logic                     r_last;

    logic [SAMPLE_BITS-1:0]        s1;
    logic [SAMPLE_BITS-1:0]        s2;
    logic [SAMPLE_BITS-1:0]        s3;
    logic signed [SAMPLE_BITS:0]   d_num;
    logic signed [SAMPLE_BITS+1:0] d_den;
    logic signed [PB_NUM-1:0]      n_num;
    logic signed [PB_DEN-1:0]      n_den;
    logic                          accept;

    assign s1 = i_data[SAMPLE_BITS-1:0];
    assign s2 = i_data[2*SAMPLE_BITS-1:SAMPLE_BITS];
    assign s3 = i_data[3*SAMPLE_BITS-1:2*SAMPLE_BITS];

    always_comb begin
        d_num = $signed({1'b0, s3}) - $signed({1'b0, s2});
        d_den = $signed({1'b0, s1, 1'b0}) - $signed({2'b00, s2}) - $signed({2'b00, s3});
        n_num = r_num_coef * d_num;
        n_den = r_den_coef * d_den;
    end

    // The product register moves on whenever the queue can take what it holds.
    assign o_ready     = !r_valid || !i_q_stat.full;
    assign accept      = i_valid && o_ready;
    assign o_push      = r_valid && !i_q_stat.full;
    assign o_push_data = {r_last, r_lit, r_den, r_num};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_coef <= NUM_COEF_RESET;
            r_den_coef <= DEN_COEF_RESET;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_index))
                REG_NUM_COEF: r_num_coef <= i_cfg_data;
                REG_DEN_COEF: r_den_coef <= i_cfg_data;
                default:      ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_num  <= n_num;
            r_den  <= n_den;
            r_lit  <= i_lit;
            r_last <= i_last;
        end
    end

endmodule

### hw/rtl/tsps_queue.sv
module tsps_queue #(
    parameter int QW = 53
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [QW-1:0]     i_push_data,
    input  logic              i_pop,
    output logic [QW-1:0]     o_head,
    output tsps_pkg::t_q_stat o_stat
);
    import tsps_pkg::*;

    localparam int DEPTH = 4;
    localparam int AW    = $clog2(DEPTH);

    logic [QW-1:0] r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr;
    logic [AW-1:0] r_rd_ptr;
    logic [AW:0]   r_count;
    logic          do_push;
    logic          do_pop;

    assign o_stat.full  = (r_count == (AW+1)'(DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;
    assign o_head       = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

### hw/rtl/tsps_cordic.sv
module tsps_cordic #(
    parameter int SAMPLE_BITS = 8,
    parameter int PHASE_BITS  = 16,
    parameter int QW          = 53
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [QW-1:0]         i_head,
    input  tsps_pkg::t_q_stat     i_q_stat,
    output logic                  o_pop,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [PHASE_BITS-1:0] o_phase,
    output logic                  o_lit,
    output logic                  o_last
);
    import tsps_pkg::*;

    localparam int PB_NUM = COEF_BITS + SAMPLE_BITS + 1;
    localparam int PB_DEN = COEF_BITS + SAMPLE_BITS + 2;
    localparam int CW     = PB_DEN + PRESCALE_BITS + GUARD_BITS;
    localparam int STEPS  = CORDIC_STEPS;
    localparam logic [31:0] HALF_LSB = 32'(1) << (31 - PHASE_BITS);

    logic signed [CW-1:0] r_x    [STEPS+1];
    logic signed [CW-1:0] r_y    [STEPS+1];
    logic [31:0]          r_acc  [STEPS+1];
    logic                 r_zero [STEPS+1];
    logic                 r_lit  [STEPS+1];
    logic                 r_last [STEPS+1];
    logic                 r_valid[STEPS+1];

    logic signed [CW-1:0] n_x  [STEPS+1];
    logic signed [CW-1:0] n_y  [STEPS+1];
    logic [31:0]          n_acc[STEPS+1];

    logic                  r_out_valid;
    logic [PHASE_BITS-1:0] r_out_phase;
    logic                  r_out_lit;
    logic                  r_out_last;

    logic signed [PB_NUM-1:0] q_num;
    logic signed [PB_DEN-1:0] q_den;
    logic                     q_lit;
    logic                     q_last;
    logic signed [CW-1:0]     num_w;
    logic signed [CW-1:0]     den_w;
    logic [31:0]              rounded;
    logic                     en;

    assign {q_last, q_lit, q_den, q_num} = i_head;

    // The whole rotation pipe advances together when the output word is free.
    assign en    = !r_out_valid || i_ready;
    assign o_pop = en && !i_q_stat.empty;

    always_comb begin
        num_w = CW'(q_num) <<< PRESCALE_BITS;
        den_w = CW'(q_den) <<< PRESCALE_BITS;
        // Fold into the right half plane, starting the angle at a half turn.
        if (q_den < 0) begin
            n_x[0]   = -den_w;
            n_y[0]   = -num_w;
            n_acc[0] = HALF_TURN;
        end else begin
            n_x[0]   = den_w;
            n_y[0]   = num_w;
            n_acc[0] = '0;
        end
        for (int k = 0; k < STEPS; k++) begin
            if (r_y[k] > 0) begin
                n_x[k+1]   = r_x[k] + (r_y[k] >>> k);
                n_y[k+1]   = r_y[k] - (r_x[k] >>> k);
                n_acc[k+1] = r_acc[k] + atan_turn(k);
            end else begin
                n_x[k+1]   = r_x[k] - (r_y[k] >>> k);
                n_y[k+1]   = r_y[k] + (r_x[k] >>> k);
                n_acc[k+1] = r_acc[k] - atan_turn(k);
            end
        end
        rounded = r_acc[STEPS] + HALF_LSB;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= STEPS; k++) begin
                r_valid[k] <= 1'b0;
            end
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_valid[0] <= !i_q_stat.empty;
            for (int k = 0; k < STEPS; k++) begin
                r_valid[k+1] <= r_valid[k];
            end
            r_out_valid <= r_valid[STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_x[0]    <= n_x[0];
            r_y[0]    <= n_y[0];
            r_acc[0]  <= n_acc[0];
            r_zero[0] <= (q_num == '0) && (q_den == '0);
            r_lit[0]  <= q_lit;
            r_last[0] <= q_last;
            for (int k = 0; k < STEPS; k++) begin
                r_x[k+1]    <= n_x[k+1];
                r_y[k+1]    <= n_y[k+1];
                r_acc[k+1]  <= n_acc[k+1];
                r_zero[k+1] <= r_zero[k];
                r_lit[k+1]  <= r_lit[k];
                r_last[k+1] <= r_last[k];
            end
            // Masked pixels and a null vector both report angle zero.
            if (!r_lit[STEPS] || r_zero[STEPS]) begin
                r_out_phase <= '0;
            end else begin
                r_out_phase <= rounded[31 -: PHASE_BITS];
            end
            r_out_lit  <= r_lit[STEPS];
            r_out_last <= r_last[STEPS];
        end
    end

    assign o_valid = r_out_valid;
    assign o_phase = r_out_phase;
    assign o_lit   = r_out_lit;
    assign o_last  = r_out_last;

endmodule

### hw/rtl/tsps_checker.sv
module tsps_checker #(
    parameter int OUT_W = 16
) (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_m_axis_tready,
    input logic             o_m_axis_tvalid,
    input logic [OUT_W-1:0] o_m_axis_tdata,
    input logic [0:0]       o_m_axis_tuser
);

    // A stalled output word holds its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("output word changed while stalled");

    // A masked pixel always reports angle zero.
    a_masked_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tuser[0] |-> o_m_axis_tdata == '0)
        else $error("masked pixel with nonzero phase");

    // Reset empties the pipeline: no word is offered right after it.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid right after reset");

endmodule

bind three_step_phase_shift_top tsps_checker #(
    .OUT_W(OUT_W)
) u_tsps_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_m_axis_tready(i_m_axis_tready),
    .o_m_axis_tvalid(o_m_axis_tvalid),
    .o_m_axis_tdata (o_m_axis_tdata),
    .o_m_axis_tuser (o_m_axis_tuser)
);
